FILE: sv/nts_pkg.sv
// shared types and constants for the nearest two point search
package nts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COORD_WIDTH = 24;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SLOT_W      = 8;
  localparam int RAD_W       = 24;
  localparam int RSQ_W       = 2 * RAD_W;
  localparam int MAG_W       = COORD_WIDTH + 1;
  localparam int DIST_W      = 2 * COORD_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [DIST_W-1:0]             dist_val_t;
  typedef logic [IDX_W-1:0]              idx_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic      valid;
    idx_t      slot;
    dist_val_t d;
  } dist_t;

  typedef struct packed {
    logic      n_ok;
    idx_t      n_slot;
    dist_val_t n_d;
    logic      s_ok;
    idx_t      s_slot;
  } rank_t;

endpackage

FILE: sv/nts_cell.sv
// one table slot of the point ring, rotates toward slot zero during a scan
module nts_cell import nts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       wr_en,
  input  point_t     wr_pt,
  input  point_t     nb_pt,
  output point_t     pt
);

  logic   valid_r;
  coord_t x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= wr_pt.valid;
    end else if (ctrl.shift) begin
      valid_r <= nb_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_r <= wr_pt.x;
      y_r <= wr_pt.y;
      z_r <= wr_pt.z;
    end else if (ctrl.shift) begin
      x_r <= nb_pt.x;
      y_r <= nb_pt.y;
      z_r <= nb_pt.z;
    end
  end

  assign pt = '{valid: valid_r, x: x_r, y: y_r, z: z_r};

endmodule

FILE: sv/nts_dist.sv
// three stage squared distance pipeline: magnitudes, squares, sum
module nts_dist import nts_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   feed_valid,
  input  idx_t   feed_slot,
  input  point_t feed_pt,
  input  coord_t qx,
  input  coord_t qy,
  input  coord_t qz,
  output dist_t  dsq
);

  logic [MAG_W-1:0]  mx_r, my_r, mz_r;
  logic [DIST_W-1:0] sx_r, sy_r, sz_r;
  dist_val_t         d_r;
  logic              v1_r, v2_r, v3_r;
  idx_t              slot1_r, slot2_r, slot3_r;

  function automatic logic [MAG_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [MAG_W-1:0] diff;
    diff = MAG_W'(a) - MAG_W'(b);
    return diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= feed_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= abs_diff(feed_pt.x, qx);
    my_r    <= abs_diff(feed_pt.y, qy);
    mz_r    <= abs_diff(feed_pt.z, qz);
    slot1_r <= feed_slot;
    sx_r    <= DIST_W'(mx_r) * DIST_W'(mx_r);
    sy_r    <= DIST_W'(my_r) * DIST_W'(my_r);
    sz_r    <= DIST_W'(mz_r) * DIST_W'(mz_r);
    slot2_r <= slot1_r;
    // three squares of at most 2^(2*coord) each fit the distance width
    d_r     <= sx_r + sy_r + sz_r;
    slot3_r <= slot2_r;
  end

  assign dsq = '{valid: v3_r, slot: slot3_r, d: d_r};

endmodule

FILE: sv/nts_rank.sv
// running nearest within radius and best / second best over all slots
module nts_rank import nts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             init,
  input  logic             limit,
  input  logic [RSQ_W-1:0] radius_sq,
  input  dist_t            dsq,
  output rank_t            rank
);

  logic      n_ok_r, b_ok_r, s_ok_r;
  idx_t      n_slot_r, b_slot_r, s_slot_r;
  dist_val_t n_d_r, b_d_r, s_d_r;

  logic in_rad, take_n, take_b, take_s;

  always_comb begin
    in_rad = !limit || (dsq.d <= DIST_W'(radius_sq));
    take_n = dsq.valid && in_rad && (!n_ok_r || dsq.d < n_d_r);
    take_b = dsq.valid && (!b_ok_r || dsq.d < b_d_r);
    // a tie with the best falls through to the second
    take_s = dsq.valid && !take_b && (!s_ok_r || dsq.d < s_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_ok_r <= 1'b0;
      b_ok_r <= 1'b0;
      s_ok_r <= 1'b0;
    end else if (init) begin
      n_ok_r <= 1'b0;
      b_ok_r <= 1'b0;
      s_ok_r <= 1'b0;
    end else begin
      if (take_n) n_ok_r <= 1'b1;
      if (take_b) begin
        b_ok_r <= 1'b1;
        if (b_ok_r) s_ok_r <= 1'b1;
      end else if (take_s) begin
        s_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_n) begin
      n_slot_r <= dsq.slot;
      n_d_r    <= dsq.d;
    end
    if (take_b) begin
      b_slot_r <= dsq.slot;
      b_d_r    <= dsq.d;
      s_slot_r <= b_slot_r;
      s_d_r    <= b_d_r;
    end else if (take_s) begin
      s_slot_r <= dsq.slot;
      s_d_r    <= dsq.d;
    end
  end

  assign rank = '{n_ok:   n_ok_r,
                  n_slot: n_ok_r ? n_slot_r : '0,
                  n_d:    n_ok_r ? n_d_r : '0,
                  s_ok:   s_ok_r,
                  s_slot: s_ok_r ? s_slot_r : '0};

endmodule

FILE: sv/nearest_two_point_search.sv
// Nearest and second nearest search over a 256 slot table of signed 3D points.
// Writes and clears are accepted back to back. A query keeps busy high while
// the point ring rotates one slot per cycle past a single three stage distance
// pipeline, then while that pipeline drains (ST_DRAIN) and while ST_DONE shows
// the result. The result word is on the out_ ports for exactly one cycle with
// out_valid high; it is not held, so the receiver must take it then. Writes
// and clears give no word.
module nearest_two_point_search import nts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_op,
  input  logic [SLOT_W-1:0]      in_entry_index,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic [RAD_W-1:0]       in_search_radius,
  output logic                   out_valid,
  output logic                   out_nearest_found,
  output logic [SLOT_W-1:0]      out_nearest_slot,
  output logic [DIST_W-1:0]      out_nearest_distance_sq,
  output logic                   out_second_found,
  output logic [SLOT_W-1:0]      out_second_slot
);

  localparam int DRAIN_CYC = 3;

  state_t           state_r, state_nxt;
  idx_t             cnt_r, cnt_nxt;
  coord_t           qx_r, qy_r, qz_r;
  logic             limit_r;
  logic [RSQ_W-1:0] radius_sq_r;

  logic       accept, do_write, do_clear, do_query;
  logic       shift, feed_valid, init;
  cell_ctrl_t ctrl;
  point_t     wr_pt;
  point_t     cell_pt [TABLE_DEPTH];
  dist_t      dsq;
  rank_t      rank;

  assign accept   = start && !busy;
  assign do_write = accept && (in_op == OP_WRITE);
  assign do_clear = accept && (in_op == OP_CLEAR);
  assign do_query = accept && (in_op == OP_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    shift      = 1'b0;
    feed_valid = 1'b0;
    init       = 1'b0;
    out_valid  = 1'b0;
    busy       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (do_query) begin
          init      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift      = 1'b1;
        feed_valid = cell_pt[0].valid;
        cnt_nxt    = cnt_r + 1'b1;
        // a full turn leaves the ring where it started
        if (cnt_r == idx_t'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == idx_t'(DRAIN_CYC - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      qx_r        <= in_pos_x;
      qy_r        <= in_pos_y;
      qz_r        <= in_pos_z;
      limit_r     <= (in_search_radius != '0);
      radius_sq_r <= RSQ_W'(in_search_radius) * RSQ_W'(in_search_radius);
    end
  end

  assign ctrl  = '{shift: shift, clear: do_clear};
  assign wr_pt = '{valid: 1'b1, x: in_pos_x, y: in_pos_y, z: in_pos_z};

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    localparam int NB = (k + 1) % TABLE_DEPTH;
    nts_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .wr_en (do_write && (in_entry_index == SLOT_W'(k))),
      .wr_pt (wr_pt),
      .nb_pt (cell_pt[NB]),
      .pt    (cell_pt[k])
    );
  end

  nts_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_valid (feed_valid),
    .feed_slot  (cnt_r),
    .feed_pt    (cell_pt[0]),
    .qx         (qx_r),
    .qy         (qy_r),
    .qz         (qz_r),
    .dsq        (dsq)
  );

  nts_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .init      (init),
    .limit     (limit_r),
    .radius_sq (radius_sq_r),
    .dsq       (dsq),
    .rank      (rank)
  );

  assign out_nearest_found       = rank.n_ok;
  assign out_nearest_slot        = SLOT_W'(rank.n_slot);
  assign out_nearest_distance_sq = rank.n_d;
  assign out_second_found        = rank.s_ok;
  assign out_second_slot         = SLOT_W'(rank.s_slot);

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_query |=> busy)
    else $error("query accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result word");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nearest_found |-> out_nearest_distance_sq == '0)
    else $error("distance reported with no nearest slot");

  a_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nearest_found && limit_r |->
      out_nearest_distance_sq <= DIST_W'(radius_sq_r))
    else $error("nearest slot outside radius");

  a_no_feed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !dsq.valid)
    else $error("distance word while idle");

endmodule
